### hw/rtl/r11das_pkg.sv
// shared types, constants and digit helpers for the radix-11 add/subtract/compare block
// no dependencies
`default_nettype none

package r11das_pkg;

    localparam int MAX_DIGITS = 64;
    localparam int LEN_W      = 7;
    localparam int CHAR_W     = 8;
    localparam int VAL_W      = 4;
    localparam int SUM_W      = 5;

    localparam logic [SUM_W-1:0] RADIX = SUM_W'(11);

    localparam logic [1:0] REQ_ADD = 2'd0;
    localparam logic [1:0] REQ_SUB = 2'd1;

    localparam logic [1:0] ORD_LESS    = 2'd0;
    localparam logic [1:0] ORD_EQUAL   = 2'd1;
    localparam logic [1:0] ORD_GREATER = 2'd2;

    localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_ONE  = 8'h31;
    localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_TEN  = 8'h41;

    localparam logic [VAL_W-1:0] VAL_TEN = 4'd10;

    localparam logic KIND_DIGIT   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic             bad;
        logic [VAL_W-1:0] val;
    } t_dec;

    // one queued job: up to a digit, a final carry digit and a summary
    typedef struct packed {
        logic              has_digit;
        logic [CHAR_W-1:0] digit_char;
        logic              has_carry;
        logic              has_sum;
        logic [LEN_W-1:0]  digit_len;
        logic              negative;
        logic [1:0]        order;
        logic              bad_digit;
    } t_job;

    typedef struct packed {
        logic              item_kind;
        logic [CHAR_W-1:0] digit_char;
        logic [LEN_W-1:0]  digit_len;
        logic              negative;
        logic [1:0]        order;
        logic              bad_digit;
        logic              end_of_run;
    } t_res;

    function automatic t_dec decode_digit(input logic [CHAR_W-1:0] c);
        t_dec d;
        d.bad = 1'b0;
        d.val = '0;
        if (c inside {[CHAR_ZERO:CHAR_NINE]}) begin
            d.val = VAL_W'(c - CHAR_ZERO);
        end else if (c == CHAR_TEN) begin
            d.val = VAL_TEN;
        end else begin
            d.bad = 1'b1;
        end
        return d;
    endfunction

    function automatic logic [CHAR_W-1:0] encode_digit(input logic [VAL_W-1:0] v);
        logic [CHAR_W-1:0] c;
        c = (v == VAL_TEN) ? CHAR_TEN : (CHAR_ZERO + CHAR_W'(v));
        return c;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/r11das_if.sv
// valid/ready channel interfaces for the request and result streams
// depends on r11das_pkg for field widths
`default_nettype none

interface r11das_req_if;
    logic                            valid;
    logic                            ready;
    logic [1:0]                      req_type;
    logic [r11das_pkg::CHAR_W-1:0]   lhs_digit;
    logic [r11das_pkg::CHAR_W-1:0]   rhs_digit;
    logic                            first_digit;
    logic                            last_digit;

    modport source (output valid, req_type, lhs_digit, rhs_digit, first_digit, last_digit,
                    input ready);
    modport sink (input valid, req_type, lhs_digit, rhs_digit, first_digit, last_digit,
                  output ready);
endinterface

interface r11das_res_if;
    logic                            valid;
    logic                            ready;
    logic                            item_kind;
    logic [r11das_pkg::CHAR_W-1:0]   digit_char;
    logic [r11das_pkg::LEN_W-1:0]    digit_len;
    logic                            negative;
    logic [1:0]                      order;
    logic                            bad_digit;
    logic                            end_of_run;

    modport source (output valid, item_kind, digit_char, digit_len, negative, order,
                    bad_digit, end_of_run, input ready);
    modport sink (input valid, item_kind, digit_char, digit_len, negative, order,
                  bad_digit, end_of_run, output ready);
endinterface

`default_nettype wire

### hw/rtl/r11das_front.sv
// front end: accepts digit pairs, runs carry/borrow, order and length state, builds jobs
// depends on r11das_pkg and r11das_req_if
`default_nettype none

module r11das_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    r11das_req_if.sink             i_req,
    output logic                   o_push_valid,
    input  wire logic              i_push_ready,
    output r11das_pkg::t_job       o_push_job
);

    logic                                r_carry;
    logic [1:0]                          r_order;
    logic [r11das_pkg::LEN_W-1:0]        r_pos;
    logic [r11das_pkg::LEN_W-1:0]        r_hnz;
    logic                                r_bad;

    logic                                n_carry;
    logic [1:0]                          n_order;
    logic [r11das_pkg::LEN_W-1:0]        n_pos;
    logic [r11das_pkg::LEN_W-1:0]        n_hnz;
    logic                                n_bad;

    r11das_pkg::t_dec                    dec_l;
    r11das_pkg::t_dec                    dec_r;
    logic [r11das_pkg::SUM_W-1:0]        sum;
    logic [r11das_pkg::SUM_W-1:0]        sub;
    logic [r11das_pkg::VAL_W-1:0]        dval;
    logic                                in_range;
    logic                                is_add;
    logic                                is_sub;
    logic                                accept;
    r11das_pkg::t_job                    job;

    assign is_add = (i_req.req_type == r11das_pkg::REQ_ADD);
    assign is_sub = (i_req.req_type == r11das_pkg::REQ_SUB);
    assign dec_l  = r11das_pkg::decode_digit(i_req.lhs_digit);
    assign dec_r  = r11das_pkg::decode_digit(i_req.rhs_digit);

    always_comb begin
        // a first mark starts from cleared state
        n_carry = i_req.first_digit ? 1'b0 : r_carry;
        n_order = i_req.first_digit ? r11das_pkg::ORD_EQUAL : r_order;
        n_pos   = i_req.first_digit ? '0 : r_pos;
        n_hnz   = i_req.first_digit ? '0 : r_hnz;
        n_bad   = i_req.first_digit ? 1'b0 : r_bad;

        in_range = (n_pos < r11das_pkg::LEN_W'(r11das_pkg::MAX_DIGITS));
        sum  = r11das_pkg::SUM_W'(dec_l.val) + r11das_pkg::SUM_W'(dec_r.val)
             + r11das_pkg::SUM_W'(n_carry);
        sub  = r11das_pkg::SUM_W'(dec_r.val) + r11das_pkg::SUM_W'(n_carry);
        dval = '0;
        job  = '0;

        if (in_range) begin
            if (dec_l.val > dec_r.val) begin
                n_order = r11das_pkg::ORD_GREATER;
            end else if (dec_l.val < dec_r.val) begin
                n_order = r11das_pkg::ORD_LESS;
            end
            if (dec_l.bad || dec_r.bad) begin
                n_bad = 1'b1;
            end
            if (is_add) begin
                n_carry = (sum >= r11das_pkg::RADIX);
                dval    = n_carry ? r11das_pkg::VAL_W'(sum - r11das_pkg::RADIX)
                                  : r11das_pkg::VAL_W'(sum);
            end else if (is_sub) begin
                if (r11das_pkg::SUM_W'(dec_l.val) >= sub) begin
                    dval    = r11das_pkg::VAL_W'(r11das_pkg::SUM_W'(dec_l.val) - sub);
                    n_carry = 1'b0;
                end else begin
                    dval    = r11das_pkg::VAL_W'(r11das_pkg::SUM_W'(dec_l.val)
                                                 + r11das_pkg::RADIX - sub);
                    n_carry = 1'b1;
                end
            end
            if (is_add || is_sub) begin
                if (dval != '0) begin
                    n_hnz = n_pos + r11das_pkg::LEN_W'(1);
                end
                job.has_digit  = 1'b1;
                job.digit_char = r11das_pkg::encode_digit(dval);
            end
            n_pos = n_pos + r11das_pkg::LEN_W'(1);
        end

        if (i_req.last_digit) begin
            job.has_sum   = 1'b1;
            job.order     = n_order;
            job.bad_digit = n_bad;
            if (is_add) begin
                if (n_carry) begin
                    job.has_carry = 1'b1;
                    n_hnz         = n_pos + r11das_pkg::LEN_W'(1);
                end
                job.digit_len = n_hnz;
            end else if (is_sub) begin
                job.negative  = n_carry;
                job.digit_len = n_carry ? '0 : n_hnz;
            end
        end
    end

    assign i_req.ready  = i_push_ready;
    assign accept       = i_req.valid && i_push_ready;
    assign o_push_valid = accept && (job.has_digit || job.has_sum);
    assign o_push_job   = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_carry <= 1'b0;
            r_order <= r11das_pkg::ORD_EQUAL;
            r_pos   <= '0;
            r_hnz   <= '0;
            r_bad   <= 1'b0;
        end else if (accept) begin
            if (i_req.last_digit) begin
                r_carry <= 1'b0;
                r_order <= r11das_pkg::ORD_EQUAL;
                r_pos   <= '0;
                r_hnz   <= '0;
                r_bad   <= 1'b0;
            end else begin
                r_carry <= n_carry;
                r_order <= n_order;
                r_pos   <= n_pos;
                r_hnz   <= n_hnz;
                r_bad   <= n_bad;
            end
        end
    end

endmodule

`default_nettype wire

### hw/rtl/r11das_queue.sv
// two-entry job queue between the front end and the result sequencer
// depends on r11das_pkg
`default_nettype none

module r11das_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push_valid,
    output logic                   o_push_ready,
    input  r11das_pkg::t_job       i_push_job,
    output logic                   o_pop_valid,
    input  wire logic              i_pop,
    output r11das_pkg::t_job       o_pop_job
);

    r11das_pkg::t_job r_mem [2];
    logic             r_wptr;
    logic             r_rptr;
    logic [1:0]       r_count;
    logic             push;
    logic             pop;

    assign o_push_ready = (r_count != 2'd2);
    assign o_pop_valid  = (r_count != 2'd0);
    assign o_pop_job    = r_mem[r_rptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_push_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push) begin
                r_wptr <= ~r_wptr;
            end
            if (pop) begin
                r_rptr <= ~r_rptr;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

### hw/rtl/r11das_back.sv
// back end: walks each queued job and sends its digit, carry digit and summary items
// depends on r11das_pkg and r11das_res_if
`default_nettype none

module r11das_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_job_valid,
    input  r11das_pkg::t_job       i_job,
    output logic                   o_pop,
    r11das_res_if.source           o_res
);

    logic              r_valid;
    r11das_pkg::t_res  r_res;
    logic [1:0]        r_done;   // digit sent, carry digit sent

    logic              pend_dig;
    logic              pend_car;
    logic              more;
    logic              load;
    r11das_pkg::t_res  n_res;
    logic [1:0]        n_done;

    assign pend_dig = i_job.has_digit && !r_done[0];
    assign pend_car = i_job.has_carry && !r_done[1];
    assign load     = i_job_valid && (!r_valid || o_res.ready);

    always_comb begin
        n_res  = '0;
        n_done = r_done;
        more   = 1'b0;
        if (pend_dig) begin
            n_res.item_kind  = r11das_pkg::KIND_DIGIT;
            n_res.digit_char = i_job.digit_char;
            more             = i_job.has_carry || i_job.has_sum;
            n_done[0]        = 1'b1;
        end else if (pend_car) begin
            n_res.item_kind  = r11das_pkg::KIND_DIGIT;
            n_res.digit_char = r11das_pkg::CHAR_ONE;
            more             = i_job.has_sum;
            n_done[1]        = 1'b1;
        end else begin
            n_res.item_kind = r11das_pkg::KIND_SUMMARY;
            n_res.digit_len = i_job.digit_len;
            n_res.negative  = i_job.negative;
            n_res.order     = i_job.order;
            n_res.bad_digit = i_job.bad_digit;
        end
        n_res.end_of_run = !more;
        if (!more) begin
            n_done = 2'b00;
        end
    end

    assign o_pop = load && !more;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_done  <= 2'b00;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_done  <= n_done;
            end else if (o_res.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_res.valid      = r_valid;
    assign o_res.item_kind  = r_res.item_kind;
    assign o_res.digit_char = r_res.digit_char;
    assign o_res.digit_len  = r_res.digit_len;
    assign o_res.negative   = r_res.negative;
    assign o_res.order      = r_res.order;
    assign o_res.bad_digit  = r_res.bad_digit;
    assign o_res.end_of_run = r_res.end_of_run;

endmodule

`default_nettype wire

### hw/rtl/radix11_digit_add_sub_compare.sv
// Radix-11 digit-serial adder, subtractor and comparator. Each request item carries one
// digit position of both operands, least significant first; add and subtract give one
// result digit per position, the last position adds a final carry digit (add, if a
// carry is left) and a summary item with length, negative flag, numeric order and
// bad-character flag. A new request is taken every cycle while the two-entry job queue
// has room; results leave at one per cycle from a registered output while the receiver
// is ready, so a position that makes one result sustains one item per cycle and a last
// position can make up to three result items. The first result of a request passes
// through the job queue, then the output register. Digits past MAX_DIGITS are ignored.
// depends on r11das_pkg, r11das_if, r11das_front, r11das_queue, r11das_back
`default_nettype none

module radix11_digit_add_sub_compare (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    r11das_req_if.sink       i_req,
    r11das_res_if.source     o_res
);

    logic              push_valid;
    logic              push_ready;
    r11das_pkg::t_job  push_job;
    logic              job_valid;
    logic              pop;
    r11das_pkg::t_job  job;

    r11das_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_job   (push_job)
    );

    r11das_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_job   (push_job),
        .o_pop_valid  (job_valid),
        .i_pop        (pop),
        .o_pop_job    (job)
    );

    r11das_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_pop       (pop),
        .o_res       (o_res)
    );

endmodule

`default_nettype wire

### hw/rtl/r11das_checker.sv
// port-level checks on the result stream of the radix-11 block, bound to the top level
// depends on r11das_pkg
`default_nettype none

module r11das_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_valid,
    input wire logic                          i_ready,
    input wire logic                          i_item_kind,
    input wire logic [r11das_pkg::CHAR_W-1:0] i_digit_char,
    input wire logic [r11das_pkg::LEN_W-1:0]  i_digit_len,
    input wire logic                          i_negative,
    input wire logic [1:0]                    i_order,
    input wire logic                          i_bad_digit,
    input wire logic                          i_end_of_run
);

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_digit_char) && $stable(i_item_kind)
            && $stable(i_end_of_run) && $stable(i_digit_len))
        else $error("result changed while stalled");

    // digit items leave summary fields clear
    a_digit_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_item_kind == r11das_pkg::KIND_DIGIT) |->
            (i_digit_len == '0) && !i_negative && (i_order == r11das_pkg::ORD_LESS)
            && !i_bad_digit)
        else $error("digit item with summary fields set");

    // a summary always closes the run
    a_sum_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_item_kind == r11das_pkg::KIND_SUMMARY) |-> i_end_of_run)
        else $error("summary without end of run");

    // negative result reports no length
    a_neg_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_negative |-> (i_digit_len == '0)
            && (i_item_kind == r11das_pkg::KIND_SUMMARY))
        else $error("negative result with nonzero length");

    // order code within less, equal, greater
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_item_kind == r11das_pkg::KIND_SUMMARY) |->
            (i_order == r11das_pkg::ORD_LESS) || (i_order == r11das_pkg::ORD_EQUAL)
            || (i_order == r11das_pkg::ORD_GREATER))
        else $error("bad order code");

endmodule

bind radix11_digit_add_sub_compare r11das_checker u_r11das_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (o_res.valid),
    .i_ready      (o_res.ready),
    .i_item_kind  (o_res.item_kind),
    .i_digit_char (o_res.digit_char),
    .i_digit_len  (o_res.digit_len),
    .i_negative   (o_res.negative),
    .i_order      (o_res.order),
    .i_bad_digit  (o_res.bad_digit),
    .i_end_of_run (o_res.end_of_run)
);

`default_nettype wire

### test/tb.sv
// self-checking bench for the radix-11 digit-serial add/subtract/compare block
// checks every result item against an in-bench predictor under random idling and back-pressure
// depends on r11das_pkg, r11das_if and radix11_digit_add_sub_compare
`default_nettype none

module tb;

    localparam logic [1:0] REQ_CMP     = 2'd2;
    localparam logic [1:0] REQ_CMP_ALT = 2'd3;

    localparam int RANDOM_ITEMS     = 190;
    localparam int CALM_TAIL        = 40;
    localparam int LONG_HOLD_CYCLES = 120;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int DRAIN_CYCLES     = 8;

    typedef enum int {
        STREAM_CLEAN,
        STREAM_NORMAL,
        STREAM_BROKEN
    } t_stream_mode;

    logic i_clk = 1'b0;
    logic i_rst_n;

    r11das_req_if req_ch ();
    r11das_res_if res_ch ();

    radix11_digit_add_sub_compare dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // predictor state, mirrors the block's running position state
    logic       sum_carry;
    logic [1:0] cmp_order;
    int         pos_count;
    int         top_nonzero;
    logic       bad_seen;

    r11das_pkg::t_res awaited_results[$];
    int   mismatches     = 0;
    int   positions_sent = 0;
    bit   idle_en        = 1'b1;
    bit   long_hold      = 1'b0;

    function automatic int char_digit(input logic [7:0] c);
        if (c >= r11das_pkg::CHAR_ZERO && c <= r11das_pkg::CHAR_NINE) begin
            return int'(c) - int'(r11das_pkg::CHAR_ZERO);
        end
        if (c == r11das_pkg::CHAR_TEN) begin
            return 10;
        end
        return -1;
    endfunction

    function automatic logic [7:0] value_char(input int v);
        if (v == 10) begin
            return r11das_pkg::CHAR_TEN;
        end
        return r11das_pkg::CHAR_ZERO + 8'(v);
    endfunction

    function automatic logic [7:0] random_char();
        if ($urandom_range(0, 9) == 0) begin
            return 8'($urandom_range(0, 255));
        end
        return value_char($urandom_range(0, 10));
    endfunction

    function automatic r11das_pkg::t_res make_result(input logic kind, input logic [7:0] ch,
                                                     input int len, input logic neg,
                                                     input logic [1:0] ord, input logic bad);
        r11das_pkg::t_res r;
        r.item_kind  = kind;
        r.digit_char = ch;
        r.digit_len  = r11das_pkg::LEN_W'(len);
        r.negative   = neg;
        r.order      = ord;
        r.bad_digit  = bad;
        r.end_of_run = 1'b0;
        return r;
    endfunction

    task automatic clear_digit_state();
        sum_carry   = 1'b0;
        cmp_order   = r11das_pkg::ORD_EQUAL;
        pos_count   = 0;
        top_nonzero = 0;
        bad_seen    = 1'b0;
    endtask

    // works out the result items one accepted position causes
    task automatic predict_position(input logic [1:0] op, input logic [7:0] lc,
                                    input logic [7:0] rc, input logic fst, input logic lst);
        int   lv;
        int   rv;
        int   acc;
        int   d;
        int   len;
        int   n;
        logic neg;
        r11das_pkg::t_res made [3];
        r11das_pkg::t_res tmp;
        n = 0;
        if (fst) begin
            clear_digit_state();
        end
        if (pos_count < r11das_pkg::MAX_DIGITS) begin
            lv = char_digit(lc);
            rv = char_digit(rc);
            if (lv < 0) begin
                bad_seen = 1'b1;
                lv = 0;
            end
            if (rv < 0) begin
                bad_seen = 1'b1;
                rv = 0;
            end
            if (lv > rv) begin
                cmp_order = r11das_pkg::ORD_GREATER;
            end else if (lv < rv) begin
                cmp_order = r11das_pkg::ORD_LESS;
            end
            d = 0;
            if (op == r11das_pkg::REQ_ADD) begin
                acc = lv + rv + int'(sum_carry);
                sum_carry = (acc >= 11);
                d = sum_carry ? acc - 11 : acc;
            end else if (op == r11das_pkg::REQ_SUB) begin
                acc = lv - rv - int'(sum_carry);
                sum_carry = (acc < 0);
                d = sum_carry ? acc + 11 : acc;
            end
            if (op == r11das_pkg::REQ_ADD || op == r11das_pkg::REQ_SUB) begin
                if (d != 0) begin
                    top_nonzero = pos_count + 1;
                end
                made[n] = make_result(r11das_pkg::KIND_DIGIT, value_char(d), 0, 1'b0,
                                      r11das_pkg::ORD_LESS, 1'b0);
                n++;
            end
            pos_count++;
        end
        if (lst) begin
            len = 0;
            neg = 1'b0;
            if (op == r11das_pkg::REQ_ADD) begin
                if (sum_carry) begin
                    top_nonzero = pos_count + 1;
                    made[n] = make_result(r11das_pkg::KIND_DIGIT, r11das_pkg::CHAR_ONE, 0,
                                          1'b0, r11das_pkg::ORD_LESS, 1'b0);
                    n++;
                end
                len = top_nonzero;
            end else if (op == r11das_pkg::REQ_SUB) begin
                if (sum_carry) begin
                    neg = 1'b1;
                end else begin
                    len = top_nonzero;
                end
            end
            made[n] = make_result(r11das_pkg::KIND_SUMMARY, 8'h00, len, neg, cmp_order,
                                  bad_seen);
            n++;
            clear_digit_state();
        end
        if (n > 0) begin
            tmp = made[n-1];
            tmp.end_of_run = 1'b1;
            made[n-1] = tmp;
        end
        for (int k = 0; k < n; k++) begin
            awaited_results.push_back(made[k]);
        end
    endtask

    task automatic send_position(input logic [1:0] op, input logic [7:0] lc,
                                 input logic [7:0] rc, input logic fst, input logic lst);
        if (idle_en && $urandom_range(0, 5) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= op;
        req_ch.lhs_digit   <= lc;
        req_ch.rhs_digit   <= rc;
        req_ch.first_digit <= fst;
        req_ch.last_digit  <= lst;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        predict_position(op, lc, rc, fst, lst);
        positions_sent++;
    endtask

    task automatic send_stream(input int len, input logic [1:0] op, input t_stream_mode mode);
        logic [1:0] pos_op;
        logic       fst;
        logic       lst;
        for (int k = 0; k < len; k++) begin
            pos_op = op;
            if (mode != STREAM_CLEAN && $urandom_range(0, 9) == 0) begin
                pos_op = 2'($urandom_range(0, 3));
            end
            if (mode == STREAM_BROKEN) begin
                fst = 1'($urandom_range(0, 1));
                lst = 1'($urandom_range(0, 1));
            end else begin
                // now and then the first mark is left off
                fst = (k == 0) && (mode == STREAM_CLEAN || $urandom_range(0, 19) != 0);
                lst = (k == len - 1);
            end
            send_position(pos_op, random_char(), random_char(), fst, lst);
        end
    endtask

    task automatic test_add_extremes();
        send_position(r11das_pkg::REQ_ADD, "A", "A", 1'b1, 1'b1);
        send_position(r11das_pkg::REQ_ADD, "0", "0", 1'b1, 1'b1);
        send_position(r11das_pkg::REQ_ADD, "A", "1", 1'b1, 1'b0);
        send_position(r11das_pkg::REQ_ADD, "A", "0", 1'b0, 1'b1);
    endtask

    task automatic test_subtract();
        send_position(r11das_pkg::REQ_SUB, "5", "5", 1'b1, 1'b1);
        send_position(r11das_pkg::REQ_SUB, "3", "7", 1'b1, 1'b1);
        send_position(r11das_pkg::REQ_SUB, "0", "1", 1'b1, 1'b0);
        send_position(r11das_pkg::REQ_SUB, "1", "0", 1'b0, 1'b1);
        send_position(r11das_pkg::REQ_SUB, "A", "0", 1'b1, 1'b1);
    endtask

    task automatic test_compare();
        send_position(REQ_CMP, "3", "3", 1'b1, 1'b0);
        send_position(REQ_CMP, "5", "2", 1'b0, 1'b1);
        send_position(REQ_CMP_ALT, "A", "9", 1'b1, 1'b0);
        send_position(REQ_CMP_ALT, "2", "4", 1'b0, 1'b1);
        send_position(REQ_CMP, "7", "7", 1'b1, 1'b1);
    endtask

    task automatic test_bad_chars();
        send_position(r11das_pkg::REQ_ADD, 8'hFF, 8'h00, 1'b1, 1'b1);
        send_position(r11das_pkg::REQ_SUB, "a", "@", 1'b1, 1'b1);
        send_position(REQ_CMP, ":", "/", 1'b1, 1'b1);
    endtask

    task automatic test_mixed_ops();
        send_position(r11das_pkg::REQ_ADD, "9", "5", 1'b1, 1'b0);
        send_position(r11das_pkg::REQ_SUB, "1", "3", 1'b0, 1'b0);
        send_position(REQ_CMP, "7", "7", 1'b0, 1'b1);
    endtask

    task automatic test_restart();
        send_position(r11das_pkg::REQ_ADD, "4", "4", 1'b1, 1'b0);
        send_position(r11das_pkg::REQ_ADD, "2", "2", 1'b0, 1'b1);
        // abandoned stream, the next first mark starts over
        send_position(r11das_pkg::REQ_SUB, "3", "1", 1'b1, 1'b0);
        send_position(r11das_pkg::REQ_ADD, "1", "1", 1'b1, 1'b1);
        send_position(r11das_pkg::REQ_ADD, "5", "5", 1'b0, 1'b1);
    endtask

    task automatic test_digit_overflow();
        send_stream(r11das_pkg::MAX_DIGITS + 2, r11das_pkg::REQ_ADD, STREAM_CLEAN);
        send_stream(r11das_pkg::MAX_DIGITS + 1, r11das_pkg::REQ_SUB, STREAM_CLEAN);
    endtask

    task automatic test_output_backpressure();
        long_hold = 1'b1;
        send_stream(24, r11das_pkg::REQ_ADD, STREAM_CLEAN);
    endtask

    task automatic test_random_streams();
        int start;
        int len;
        start = positions_sent;
        while (positions_sent - start < RANDOM_ITEMS) begin
            if (positions_sent - start >= RANDOM_ITEMS - CALM_TAIL) begin
                idle_en = 1'b0;
            end
            len = ($urandom_range(0, 29) == 0) ? $urandom_range(60, 68) : $urandom_range(1, 8);
            send_stream(len, 2'($urandom_range(0, 3)),
                        ($urandom_range(0, 9) == 0) ? STREAM_BROKEN : STREAM_NORMAL);
        end
    endtask

    // result receiver with random stalls and one long hold-off
    initial begin
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold) begin
                res_ch.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
                long_hold = 1'b0;
                res_ch.ready <= 1'b1;
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
                res_ch.ready <= 1'b1;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    task automatic check_field(input string fname, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
        end
    endtask

    initial begin
        r11das_pkg::t_res want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_ch.valid && res_ch.ready) begin
                if (awaited_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result item, expected none, actual kind %0d char %0h",
                             $time, res_ch.item_kind, res_ch.digit_char);
                end else begin
                    want = awaited_results.pop_front();
                    check_field("item_kind", 8'(want.item_kind), 8'(res_ch.item_kind));
                    check_field("digit_char", want.digit_char, res_ch.digit_char);
                    check_field("digit_len", 8'(want.digit_len), 8'(res_ch.digit_len));
                    check_field("negative", 8'(want.negative), 8'(res_ch.negative));
                    check_field("order", 8'(want.order), 8'(res_ch.order));
                    check_field("bad_digit", 8'(want.bad_digit), 8'(res_ch.bad_digit));
                    check_field("end_of_run", 8'(want.end_of_run), 8'(res_ch.end_of_run));
                end
            end
        end
    end

    // counts cycles with no item moving on either side
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (req_ch.valid && req_ch.ready)
                || (res_ch.valid && res_ch.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("tb failed");
        $finish;
    end

    initial begin
        i_rst_n            <= 1'b0;
        req_ch.valid       <= 1'b0;
        req_ch.req_type    <= r11das_pkg::REQ_ADD;
        req_ch.lhs_digit   <= r11das_pkg::CHAR_ZERO;
        req_ch.rhs_digit   <= r11das_pkg::CHAR_ZERO;
        req_ch.first_digit <= 1'b0;
        req_ch.last_digit  <= 1'b0;
        clear_digit_state();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_add_extremes();
        test_subtract();
        test_compare();
        test_bad_chars();
        test_mixed_ops();
        test_restart();
        test_digit_overflow();
        test_output_backpressure();
        test_random_streams();

        req_ch.valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
hw/rtl/r11das_pkg.sv
hw/rtl/r11das_if.sv
hw/rtl/r11das_front.sv
hw/rtl/r11das_queue.sv
hw/rtl/r11das_back.sv
hw/rtl/radix11_digit_add_sub_compare.sv
hw/rtl/r11das_checker.sv
test/tb.sv
